// ===== rtl/core/sdm_pkg.sv =====
// ----------------------------------------------------------------------------
// sdm_pkg
// Shared constants, register index codes and widths for the stick radial
// deadzone mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package sdm_pkg;

    // full-scale raw stick magnitude
    localparam int FULL_SCALE     = 32767;
    // default output saturation limit
    localparam int OUT_LIMIT_DEF  = 80;

    // field widths
    localparam int STICK_W        = 16;
    localparam int MOVE_W         = 8;
    localparam int DZ_W           = 16;
    localparam int SQTHR_W        = 15;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    // square root pipeline: one result bit per stage
    localparam int SQ_IN_W        = 32;
    localparam int SQ_STAGES      = 16;
    localparam int MAG_W          = 16;

    // products of a 16-bit magnitude and a 15-bit span
    localparam int PROD_W         = 31;

    // register stages outside the square root and divider pipes
    localparam int FRONT_STAGES   = 2;
    localparam int MID_STAGES     = 3;
    localparam int OUT_STAGES     = 1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIAL_MODE = 2'd0,
        REG_DEADZONE    = 2'd1,
        REG_SQ_THR      = 2'd2
    } t_reg_idx;

    // input-to-output latency for a given output limit
    function automatic int sdm_latency(input int out_limit);
        return FRONT_STAGES + SQ_STAGES + MID_STAGES + $clog2(out_limit + 1) + OUT_STAGES;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sdm_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// sdm_sqrt_pipe
// Pipelined integer square root, one result bit resolved per stage, with a
// sideband word carried alongside each item.
// ----------------------------------------------------------------------------
`default_nettype none

module sdm_sqrt_pipe #(
    parameter int SW = 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire logic [sdm_pkg::SQ_IN_W-1:0]   i_rad,
    input  wire logic [SW-1:0]                 i_side,
    output logic                               o_vld,
    output logic [sdm_pkg::MAG_W-1:0]          o_root,
    output logic [SW-1:0]                      o_side
);
    import sdm_pkg::*;

    logic [SQ_IN_W-1:0] w_v    [0:SQ_STAGES];
    logic [SQ_IN_W-1:0] w_res  [0:SQ_STAGES];
    logic [SW-1:0]      w_side [0:SQ_STAGES];
    logic               w_vld  [0:SQ_STAGES];

    assign w_v[0]    = i_rad;
    assign w_res[0]  = '0;
    assign w_side[0] = i_side;
    assign w_vld[0]  = i_vld;

    // one digit-pair per stage, highest pair first
    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        localparam logic [SQ_IN_W-1:0] BIT = SQ_IN_W'(1) << (2 * (SQ_STAGES - 1 - k));

        logic [SQ_IN_W-1:0] n_v;
        logic [SQ_IN_W-1:0] n_res;
        logic [SQ_IN_W-1:0] r_v;
        logic [SQ_IN_W-1:0] r_res;
        logic [SW-1:0]      r_side;
        logic               r_vld;

        always_comb begin
            if (w_v[k] >= w_res[k] + BIT) begin
                n_v   = w_v[k] - (w_res[k] + BIT);
                n_res = (w_res[k] >> 1) + BIT;
            end else begin
                n_v   = w_v[k];
                n_res = w_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[k];
            end
            r_v    <= n_v;
            r_res  <= n_res;
            r_side <= w_side[k];
        end

        assign w_v[k+1]    = r_v;
        assign w_res[k+1]  = r_res;
        assign w_side[k+1] = r_side;
        assign w_vld[k+1]  = r_vld;
    end

    assign o_vld  = w_vld[SQ_STAGES];
    assign o_root = w_res[SQ_STAGES][MAG_W-1:0];
    assign o_side = w_side[SQ_STAGES];

endmodule

`default_nettype wire

// ===== rtl/core/sdm_div_pipe.sv =====
// ----------------------------------------------------------------------------
// sdm_div_pipe
// Two-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage, with a sideband word carried alongside each item.
// ----------------------------------------------------------------------------
`default_nettype none

module sdm_div_pipe #(
    parameter int NW = 38,
    parameter int DW = 31,
    parameter int QW = 7,
    parameter int SW = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire logic [NW-1:0] i_num_x,
    input  wire logic [NW-1:0] i_num_y,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_vld,
    output logic [QW-1:0]      o_quo_x,
    output logic [QW-1:0]      o_quo_y,
    output logic [SW-1:0]      o_side
);
    localparam int EW = NW + DW + QW;

    logic [NW-1:0] w_rx   [0:QW];
    logic [NW-1:0] w_ry   [0:QW];
    logic [QW-1:0] w_qx   [0:QW];
    logic [QW-1:0] w_qy   [0:QW];
    logic [DW-1:0] w_den  [0:QW];
    logic [SW-1:0] w_side [0:QW];
    logic          w_vld  [0:QW];

    assign w_rx[0]   = i_num_x;
    assign w_ry[0]   = i_num_y;
    assign w_qx[0]   = '0;
    assign w_qy[0]   = '0;
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;
    assign w_vld[0]  = i_vld;

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int SH = QW - 1 - k;

        logic [EW-1:0] w_dsh;
        logic          w_tx;
        logic          w_ty;
        logic [NW-1:0] r_rx;
        logic [NW-1:0] r_ry;
        logic [QW-1:0] r_qx;
        logic [QW-1:0] r_qy;
        logic [DW-1:0] r_den;
        logic [SW-1:0] r_side;
        logic          r_vld;

        assign w_dsh = EW'(w_den[k]) << SH;
        assign w_tx  = EW'(w_rx[k]) >= w_dsh;
        assign w_ty  = EW'(w_ry[k]) >= w_dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[k];
            end
            r_rx   <= w_tx ? NW'(EW'(w_rx[k]) - w_dsh) : w_rx[k];
            r_ry   <= w_ty ? NW'(EW'(w_ry[k]) - w_dsh) : w_ry[k];
            r_qx   <= (w_qx[k] << 1) | QW'(w_tx);
            r_qy   <= (w_qy[k] << 1) | QW'(w_ty);
            r_den  <= w_den[k];
            r_side <= w_side[k];
        end

        assign w_rx[k+1]   = r_rx;
        assign w_ry[k+1]   = r_ry;
        assign w_qx[k+1]   = r_qx;
        assign w_qy[k+1]   = r_qy;
        assign w_den[k+1]  = r_den;
        assign w_side[k+1] = r_side;
        assign w_vld[k+1]  = r_vld;
    end

    assign o_vld   = w_vld[QW];
    assign o_quo_x = w_qx[QW];
    assign o_quo_y = w_qy[QW];
    assign o_side  = w_side[QW];

endmodule

`default_nettype wire

// ===== rtl/core/stick_radial_deadzone_mapper_top.sv =====
// ----------------------------------------------------------------------------
// stick_radial_deadzone_mapper_top
// Maps a raw signed stick sample to a movement pair saturated to +-OUT_LIMIT
// using either a radial deadzone or a per-axis square deadzone.
// ----------------------------------------------------------------------------
// Path: from start to o_valid through stages a and b, the 16-stage square root
// pipe, stages c to e, one divider stage per quotient bit and the output stage.
// Throughput: one item per cycle; o_busy stays low and o_valid pulses once.
// Reset: synchronous active-low; clears all valid bits and the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module stick_radial_deadzone_mapper_top #(
    parameter int OUT_LIMIT = sdm_pkg::OUT_LIMIT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic                              i_cfg_we,
    input  wire logic [sdm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [sdm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic signed [sdm_pkg::STICK_W-1:0] i_stick_x,
    input  wire logic signed [sdm_pkg::STICK_W-1:0] i_stick_y,
    output logic                                   o_valid,
    output logic signed [sdm_pkg::MOVE_W-1:0]      o_move_x,
    output logic signed [sdm_pkg::MOVE_W-1:0]      o_move_y
);
    import sdm_pkg::*;

    localparam int QW = $clog2(OUT_LIMIT + 1);
    localparam int NW = PROD_W + QW;
    localparam int SQ_SIDE_W = 2 * STICK_W + 2;

    // configuration registers
    logic               r_radial;
    logic [DZ_W-1:0]    r_dz;
    logic [SQTHR_W-1:0] r_sqthr;
    logic [SQTHR_W-1:0] r_thr;
    logic [PROD_W-1:0]  w_thr_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radial <= 1'b0;
            r_dz     <= '0;
            r_sqthr  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_RADIAL_MODE: r_radial <= i_cfg_data[0];
                REG_DEADZONE:    r_dz     <= i_cfg_data[DZ_W-1:0];
                REG_SQ_THR:      r_sqthr  <= i_cfg_data[SQTHR_W-1:0];
                default: ;
            endcase
        end
    end

    // radial threshold, recomputed from the deadzone fraction
    assign w_thr_prod = PROD_W'(r_dz) * PROD_W'(FULL_SCALE);

    always_ff @(posedge i_clk) begin
        r_thr <= w_thr_prod[PROD_W-1:PROD_W-SQTHR_W];
    end

    assign o_busy = 1'b0;

    // stage a: magnitudes and signs, vertical axis inverted
    logic               r_a_vld;
    logic [STICK_W-1:0] r_a_ax;
    logic [STICK_W-1:0] r_a_ay;
    logic               r_a_nx;
    logic               r_a_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_start;
        end
        r_a_ax <= i_stick_x[STICK_W-1] ? STICK_W'(~i_stick_x + 1'b1) : STICK_W'(i_stick_x);
        r_a_ay <= i_stick_y[STICK_W-1] ? STICK_W'(~i_stick_y + 1'b1) : STICK_W'(i_stick_y);
        r_a_nx <= i_stick_x[STICK_W-1];
        r_a_ny <= !i_stick_y[STICK_W-1] && (i_stick_y != '0);
    end

    // stage b: sum of squares
    logic                 r_b_vld;
    logic [SQ_IN_W-1:0]   r_b_sq;
    logic [SQ_SIDE_W-1:0] r_b_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_sq   <= SQ_IN_W'(r_a_ax) * SQ_IN_W'(r_a_ax) + SQ_IN_W'(r_a_ay) * SQ_IN_W'(r_a_ay);
        r_b_side <= {r_a_ax, r_a_ay, r_a_nx, r_a_ny};
    end

    // magnitude
    logic                 w_s_vld;
    logic [MAG_W-1:0]     w_s_mag;
    logic [SQ_SIDE_W-1:0] w_s_side;

    sdm_sqrt_pipe #(
        .SW (SQ_SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_b_vld),
        .i_rad   (r_b_sq),
        .i_side  (r_b_side),
        .o_vld   (w_s_vld),
        .o_root  (w_s_mag),
        .o_side  (w_s_side)
    );

    // stage c: deadzone test and clipped travel
    logic [MAG_W-1:0]   w_c_diff;
    logic [SQTHR_W-1:0] w_c_span;
    logic               r_c_vld;
    logic               r_c_pass;
    logic [MAG_W-1:0]   r_c_mag;
    logic [SQTHR_W-1:0] r_c_r;
    logic [SQTHR_W-1:0] r_c_span;
    logic [SQ_SIDE_W-1:0] r_c_side;

    assign w_c_diff = w_s_mag - MAG_W'(r_thr);
    assign w_c_span = SQTHR_W'(FULL_SCALE) - r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= w_s_vld;
        end
        r_c_pass <= w_s_mag > MAG_W'(r_thr);
        r_c_mag  <= w_s_mag;
        r_c_r    <= (w_c_diff > MAG_W'(w_c_span)) ? w_c_span : w_c_diff[SQTHR_W-1:0];
        r_c_span <= w_c_span;
        r_c_side <= w_s_side;
    end

    // stage d: divisor and scaled axis products
    logic [STICK_W-1:0] w_c_ax;
    logic [STICK_W-1:0] w_c_ay;
    logic               r_d_vld;
    logic               r_d_pass;
    logic [PROD_W-1:0]  r_d_den;
    logic [PROD_W-1:0]  r_d_px;
    logic [PROD_W-1:0]  r_d_py;
    logic [SQ_SIDE_W-1:0] r_d_side;

    assign w_c_ax = r_c_side[SQ_SIDE_W-1 -: STICK_W];
    assign w_c_ay = r_c_side[2 +: STICK_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_pass <= r_c_pass;
        r_d_den  <= PROD_W'(r_c_mag) * PROD_W'(r_c_span);
        r_d_px   <= PROD_W'(w_c_ax) * PROD_W'(r_c_r);
        r_d_py   <= PROD_W'(w_c_ay) * PROD_W'(r_c_r);
        r_d_side <= r_c_side;
    end

    // stage e: numerator and divisor selection per mode
    logic [STICK_W-1:0] w_d_ax;
    logic [STICK_W-1:0] w_d_ay;
    logic               w_d_zx;
    logic               w_d_zy;
    logic [NW-1:0]      w_d_nx;
    logic [NW-1:0]      w_d_ny;
    logic               r_e_vld;
    logic [NW-1:0]      r_e_nx;
    logic [NW-1:0]      r_e_ny;
    logic [PROD_W-1:0]  r_e_den;
    logic [1:0]         r_e_sign;

    assign w_d_ax = r_d_side[SQ_SIDE_W-1 -: STICK_W];
    assign w_d_ay = r_d_side[2 +: STICK_W];

    always_comb begin
        if (r_radial) begin
            w_d_zx = !r_d_pass;
            w_d_zy = !r_d_pass;
            w_d_nx = NW'(r_d_px) * NW'(OUT_LIMIT);
            w_d_ny = NW'(r_d_py) * NW'(OUT_LIMIT);
        end else begin
            w_d_zx = w_d_ax <= STICK_W'(r_sqthr);
            w_d_zy = w_d_ay <= STICK_W'(r_sqthr);
            w_d_nx = NW'(w_d_ax) * NW'(OUT_LIMIT);
            w_d_ny = NW'(w_d_ay) * NW'(OUT_LIMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
        r_e_nx   <= w_d_zx ? '0 : w_d_nx;
        r_e_ny   <= w_d_zy ? '0 : w_d_ny;
        r_e_den  <= !r_radial ? PROD_W'(FULL_SCALE) :
                    (r_d_pass ? r_d_den : PROD_W'(1));
        r_e_sign <= r_d_side[1:0];
    end

    // quotient magnitudes
    logic          w_q_vld;
    logic [QW-1:0] w_q_x;
    logic [QW-1:0] w_q_y;
    logic [1:0]    w_q_sign;

    sdm_div_pipe #(
        .NW (NW),
        .DW (PROD_W),
        .QW (QW),
        .SW (2)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_e_vld),
        .i_num_x (r_e_nx),
        .i_num_y (r_e_ny),
        .i_den   (r_e_den),
        .i_side  (r_e_sign),
        .o_vld   (w_q_vld),
        .o_quo_x (w_q_x),
        .o_quo_y (w_q_y),
        .o_side  (w_q_sign)
    );

    // output stage: saturate and apply sign
    logic [QW-1:0]            w_cx;
    logic [QW-1:0]            w_cy;
    logic                     r_o_vld;
    logic signed [MOVE_W-1:0] r_o_mx;
    logic signed [MOVE_W-1:0] r_o_my;

    assign w_cx = (w_q_x > QW'(OUT_LIMIT)) ? QW'(OUT_LIMIT) : w_q_x;
    assign w_cy = (w_q_y > QW'(OUT_LIMIT)) ? QW'(OUT_LIMIT) : w_q_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= w_q_vld;
        end
        r_o_mx <= w_q_sign[1] ? -MOVE_W'(w_cx) : MOVE_W'(w_cx);
        r_o_my <= w_q_sign[0] ? -MOVE_W'(w_cy) : MOVE_W'(w_cy);
    end

    assign o_valid  = r_o_vld;
    assign o_move_x = r_o_mx;
    assign o_move_y = r_o_my;

endmodule

`default_nettype wire

// ===== rtl/core/sdm_chk.sv =====
// ----------------------------------------------------------------------------
// sdm_chk
// Port-level checks for the stick deadzone mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sdm_chk #(
    parameter int OUT_LIMIT = sdm_pkg::OUT_LIMIT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic                               o_busy,
    input  wire logic signed [sdm_pkg::STICK_W-1:0] i_stick_x,
    input  wire logic signed [sdm_pkg::STICK_W-1:0] i_stick_y,
    input  wire logic                               o_valid,
    input  wire logic signed [sdm_pkg::MOVE_W-1:0]  o_move_x,
    input  wire logic signed [sdm_pkg::MOVE_W-1:0]  o_move_y
);
    import sdm_pkg::*;

    localparam int LAT = sdm_latency(OUT_LIMIT);

    logic w_acc;
    logic w_zero_in;

    assign w_acc     = i_start && !o_busy;
    assign w_zero_in = w_acc && (i_stick_x == '0) && (i_stick_y == '0);

    // reset leaves no item in flight
    a_reset_flush: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // every result comes from an item taken a fixed latency earlier
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_acc, LAT))
        else $error("result without matching item");

    // results stay within the saturation range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_move_x <= MOVE_W'(OUT_LIMIT)) && (o_move_x >= -MOVE_W'(OUT_LIMIT))
                 && (o_move_y <= MOVE_W'(OUT_LIMIT)) && (o_move_y >= -MOVE_W'(OUT_LIMIT)))
        else $error("movement out of range");

    // a centered stick gives no movement
    a_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(w_zero_in, LAT) |-> (o_move_x == '0) && (o_move_y == '0))
        else $error("centered stick moved");

endmodule

bind stick_radial_deadzone_mapper_top sdm_chk #(
    .OUT_LIMIT (OUT_LIMIT)
) u_sdm_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (i_start),
    .o_busy    (o_busy),
    .i_stick_x (i_stick_x),
    .i_stick_y (i_stick_y),
    .o_valid   (o_valid),
    .o_move_x  (o_move_x),
    .o_move_y  (o_move_y)
);

`default_nettype wire

// ===== tb/sv/sdm_checker.sv =====
// ----------------------------------------------------------------------------
// sdm_checker
// Watches accepted stick samples, configuration writes and movement results of
// the stick deadzone mapper; predicts each result and compares it in order.
// ----------------------------------------------------------------------------
module sdm_checker #(
    parameter int OUT_LIMIT = sdm_pkg::OUT_LIMIT_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic                                   i_busy,
    input  logic                                   i_cfg_we,
    input  logic [sdm_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [sdm_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic signed [sdm_pkg::STICK_W-1:0]     i_stick_x,
    input  logic signed [sdm_pkg::STICK_W-1:0]     i_stick_y,
    input  logic                                   i_valid,
    input  logic signed [sdm_pkg::MOVE_W-1:0]      i_move_x,
    input  logic signed [sdm_pkg::MOVE_W-1:0]      i_move_y,
    output int                                     o_fail_cnt,
    output int                                     o_pending,
    output int                                     o_result_cnt
);
    timeunit 1ns;
    timeprecision 1ps;
    import sdm_pkg::*;

    typedef struct packed {
        logic signed [MOVE_W-1:0] mx;
        logic signed [MOVE_W-1:0] my;
    } t_move;

    t_move          move_q[$];
    logic           radial_q;
    logic [DZ_W-1:0]    dz_q;
    logic [SQTHR_W-1:0] sqthr_q;

    // floor square root by binary search
    function automatic longint isqrt(input longint v);
        longint lo, hi, mid;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint clamp_move(input longint v);
        if (v > OUT_LIMIT) return OUT_LIMIT;
        if (v < -OUT_LIMIT) return -OUT_LIMIT;
        return v;
    endfunction

    function automatic t_move map_stick(input logic signed [STICK_W-1:0] sx,
                                        input logic signed [STICK_W-1:0] sy);
        longint x, y, mag, thr, span, r, den, mx, my;
        t_move  m;
        x  = sx;
        y  = -longint'(sy);
        mx = 0;
        my = 0;
        if (radial_q) begin
            mag = isqrt(x * x + y * y);
            thr = (longint'(dz_q) * FULL_SCALE) >>> 16;
            if (mag > thr) begin
                span = FULL_SCALE - thr;
                r    = mag - thr;
                if (r > span) r = span;
                den = mag * span;
                mx  = (x * OUT_LIMIT * r) / den;
                my  = (y * OUT_LIMIT * r) / den;
            end
        end else begin
            if ((x < 0 ? -x : x) > longint'(sqthr_q)) mx = (x * OUT_LIMIT) / FULL_SCALE;
            if ((y < 0 ? -y : y) > longint'(sqthr_q)) my = (y * OUT_LIMIT) / FULL_SCALE;
        end
        m.mx = MOVE_W'(clamp_move(mx));
        m.my = MOVE_W'(clamp_move(my));
        return m;
    endfunction

    // track registers, predict on accept, compare on strobe
    always @(posedge i_clk) begin
        t_move e;
        if (!i_rst_n) begin
            radial_q     <= 1'b0;
            dz_q         <= '0;
            sqthr_q      <= '0;
            o_fail_cnt   <= 0;
            o_result_cnt <= 0;
            move_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RADIAL_MODE: radial_q <= i_cfg_data[0];
                    REG_DEADZONE:    dz_q     <= i_cfg_data[DZ_W-1:0];
                    REG_SQ_THR:      sqthr_q  <= i_cfg_data[SQTHR_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) move_q.push_back(map_stick(i_stick_x, i_stick_y));
            if (i_valid) begin
                o_result_cnt <= o_result_cnt + 1;
                if (move_q.size() == 0) begin
                    if (o_fail_cnt < 10) $display("unexpected result %0d %0d", i_move_x, i_move_y);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    e = move_q.pop_front();
                    if (e.mx !== i_move_x || e.my !== i_move_y) begin
                        if (o_fail_cnt < 10)
                            $display("mismatch: exp x=%0d y=%0d got x=%0d y=%0d",
                                     e.mx, e.my, i_move_x, i_move_y);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
        end
    end

    always_comb o_pending = move_q.size();
endmodule

// ===== tb/sv/tb_stick_radial_deadzone_mapper_top.sv =====
// ----------------------------------------------------------------------------
// tb_stick_radial_deadzone_mapper_top
// Drives directed and random stick samples through several deadzone settings
// in bursts; the verdict comes from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_stick_radial_deadzone_mapper_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sdm_pkg::*;

    localparam int LAT   = sdm_latency(OUT_LIMIT_DEF);
    localparam int LIMIT = 20 * LAT + 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic signed [STICK_W-1:0] i_stick_x = '0;
    logic signed [STICK_W-1:0] i_stick_y = '0;
    logic o_busy, o_valid;
    logic signed [MOVE_W-1:0] o_move_x, o_move_y;
    int fail_cnt, pending, result_cnt;
    int item_cnt = 0;
    int idle_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    stick_radial_deadzone_mapper_top dut (.*);

    sdm_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_stick_x(i_stick_x), .i_stick_y(i_stick_y), .i_valid(o_valid),
        .i_move_x(o_move_x), .i_move_y(o_move_y), .o_fail_cnt(fail_cnt),
        .o_pending(pending), .o_result_cnt(result_cnt)
    );

    // watchdog on cycles with no accepted item, result or configuration write
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one item, held until accepted
    task automatic send_item(input logic signed [STICK_W-1:0] x,
                             input logic signed [STICK_W-1:0] y);
        i_start   <= 1'b1;
        i_stick_x <= x;
        i_stick_y <= y;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        item_cnt++;
    endtask

    task automatic gap(input int n);
        i_start <= 1'b0;
        i_stick_x <= 16'($urandom);
        i_stick_y <= 16'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    // wait until all results are in, then let the pipe drain
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    // one register write; the caller drops the write enable after the last one
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
    endtask

    task automatic set_mode(input logic rad, input logic [15:0] dz, input logic [15:0] th);
        write_reg(REG_RADIAL_MODE, {15'($urandom), rad});
        write_reg(REG_DEADZONE, dz);
        write_reg(REG_SQ_THR, th);
        i_cfg_we <= 1'b0;
    endtask

    // random sample, biased toward edges and the deadzone boundary
    task automatic rand_item();
        logic signed [STICK_W-1:0] x, y;
        case ($urandom_range(0, 5))
            0: begin x = 16'sh8000; y = 16'($urandom); end
            1: begin x = 16'($urandom); y = 16'sh8000; end
            2: begin
                x = STICK_W'(int'($urandom_range(0, 600)) - 300);
                y = STICK_W'(int'($urandom_range(0, 600)) - 300);
            end
            3: begin x = 16'($urandom_range(0, 1) ? 32767 : -32767); y = 16'($urandom); end
            default: begin x = 16'($urandom); y = 16'($urandom); end
        endcase
        send_item(x, y);
    endtask

    task automatic rand_phase(input int n);
        int k;
        k = 0;
        while (k < n) begin
            repeat ($urandom_range(1, 20)) begin
                rand_item();
                k++;
            end
            if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 6));
        end
    endtask

    initial begin
        logic signed [STICK_W-1:0] xs[6];
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: square mode, reset values, then extremes
        xs = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1, 16'sh0100};
        foreach (xs[i]) send_item(xs[i], xs[5 - i]);
        send_item(16'sh8000, 16'sh8000);
        drain();
        set_mode(1'b0, 16'h0000, 16'h7fff);
        send_item(16'sh7fff, 16'sh8000);
        send_item(16'sh4000, -16'sd4000);
        drain();
        set_mode(1'b1, 16'h0000, 16'h0100);
        foreach (xs[i]) send_item(xs[i], xs[(i + 2) % 6]);
        send_item(16'sh8000, 16'sh8000);
        drain();
        // full deadzone
        set_mode(1'b1, 16'hffff, 16'h0000);
        send_item(16'sh7fff, 16'sh0000);
        send_item(16'sh0000, 16'sh8000);
        send_item(16'sh7ffe, 16'sh0000);
        send_item(16'sh5a82, 16'sh5a82);
        drain();

        // random phases across settings, extremes included
        set_mode(1'b1, 16'h4000, 16'h0000); rand_phase(250); drain();
        set_mode(1'b0, 16'h0000, 16'h1000); rand_phase(200); drain();
        set_mode(1'b1, 16'($urandom), 16'($urandom)); rand_phase(250); drain();
        set_mode(1'b0, 16'($urandom), 16'h7fff); rand_phase(150); drain();
        set_mode(1'b1, 16'hffff, 16'h0000); rand_phase(150); drain();
        set_mode(1'b0, 16'hffff, 16'($urandom_range(0, 400))); rand_phase(200); drain();
        set_mode(1'b1, 16'h0001, 16'h0000); rand_phase(250); drain();

        $display("covered %0d items, %0d results, radial and square modes", item_cnt,
                 result_cnt);
        $display("deadzone settings from zero to full, thresholds from zero to max");
        if (fail_cnt == 0 && pending == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
